[sv/fbde_pkg.sv]
// Shared types, codes and helpers for the page framebuffer draw engine.
package fbde_pkg;

	localparam int SCREEN_WIDTH_DEF  = 128;
	localparam int SCREEN_HEIGHT_DEF = 64;
	localparam int ROWS_PER_PAGE     = 8;

	typedef enum logic [2:0] {
		OP_PIXEL = 3'd0,
		OP_HLINE = 3'd1,
		OP_VLINE = 3'd2,
		OP_RECT  = 3'd3,
		OP_CLEAR = 3'd4,
		OP_FILL  = 3'd5,
		OP_READ  = 3'd6,
		OP_NOP   = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		INK_SET   = 2'd0,
		INK_CLEAR = 2'd1,
		INK_FLIP  = 2'd2,
		INK_KEEP  = 2'd3
	} color_t;

	// Command payload, one drawing or read transaction.
	typedef struct packed {
		logic        [2:0]  operation;
		logic signed [15:0] x_first;
		logic signed [15:0] x_second;
		logic signed [15:0] y_first;
		logic signed [15:0] y_second;
		logic        [15:0] rect_width;
		logic        [15:0] rect_height;
		logic        [1:0]  color;
		logic        [2:0]  read_page;
		logic        [6:0]  read_column;
	} cmd_t;

	// Controller to datapath.
	typedef struct packed {
		logic load_cmd;
		logic load_box;
		logic load_clip;
		logic mem_rd;
		logic mem_wr;
		logic sweep_start;
		logic sweep_white;
		logic sweep_wr;
		logic rd_issue;
		logic rd_done;
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		opcode_t op;
		logic    box_empty;
		logic    last_byte;
		logic    sweep_last;
		logic    out_busy;
	} dp_status_t;

	// Apply one color to the bits of a byte selected by mask.
	function automatic logic [7:0] apply_color(input logic [7:0] data, input logic [7:0] mask,
			input logic [1:0] color);
		logic [7:0] res;
		unique case (color_t'(color))
			INK_SET:   res = data | mask;
			INK_CLEAR: res = data & ~mask;
			INK_FLIP:  res = data ^ mask;
			default:   res = data;
		endcase
		return res;
	endfunction

endpackage

[sv/fbde_chan_if.sv]
// Valid/ready channel interface carrying one payload per transaction.
interface fbde_chan_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/fbde_ctrl.sv]
// Controller state machine sequencing setup, read-modify-write, sweeps and reads.
module fbde_ctrl
	import fbde_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_SWEEP  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_BOX    = 8'b0000_0100,
		S_CLIP   = 8'b0000_1000,
		S_RD     = 8'b0001_0000,
		S_WR     = 8'b0010_0000,
		S_RDWAIT = 8'b0100_0000,
		S_RDOUT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_SWEEP: begin
				cmd.sweep_wr = 1'b1;
				if (status.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_cmd = 1'b1;
					state_d      = S_BOX;
				end
			end
			S_BOX: begin
				unique case (status.op)
					OP_PIXEL, OP_HLINE, OP_VLINE, OP_RECT: begin
						cmd.load_box = 1'b1;
						state_d      = S_CLIP;
					end
					OP_CLEAR: begin
						cmd.sweep_start = 1'b1;
						state_d         = S_SWEEP;
					end
					OP_FILL: begin
						cmd.sweep_start = 1'b1;
						cmd.sweep_white = 1'b1;
						state_d         = S_SWEEP;
					end
					OP_READ: state_d = S_RDWAIT;
					default: state_d = S_IDLE;
				endcase
			end
			S_CLIP: begin
				cmd.load_clip = 1'b1;
				state_d       = status.box_empty ? S_IDLE : S_RD;
			end
			S_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_WR;
			end
			S_WR: begin
				cmd.mem_wr = 1'b1;
				state_d    = status.last_byte ? S_IDLE : S_RD;
			end
			S_RDWAIT: begin
				if (!status.out_busy) begin
					cmd.rd_issue = 1'b1;
					state_d      = S_RDOUT;
				end
			end
			S_RDOUT: begin
				cmd.rd_done = 1'b1;
				state_d     = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[sv/fbde_dp.sv]
// Datapath: command register, clipping, frame store memory and read-out register.
module fbde_dp
	import fbde_pkg::*;
#(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  cmd,
	output dp_status_t status,
	input  cmd_t       in_data,
	output logic       out_valid,
	output logic [7:0] out_data,
	input  logic       out_ready
);

	localparam int PAGE_COUNT  = (SCREEN_HEIGHT + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
	localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam int CW          = $clog2(SCREEN_WIDTH);
	localparam int PW          = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

	localparam logic signed [17:0] X_MAX = 18'(SCREEN_WIDTH - 1);
	localparam logic signed [17:0] Y_MAX = 18'(SCREEN_HEIGHT - 1);

	cmd_t cmd_q;

	logic signed [17:0] bx0_q, bx1_q, by0_q, by1_q;
	logic signed [17:0] bx0_d, bx1_d, by0_d, by1_d;
	logic signed [17:0] cx0, cx1, cy0, cy1;

	logic [CW-1:0] col_lo_q, col_hi_q, col_q;
	logic [PW-1:0] page_lo_q, page_hi_q, page_q;
	logic [2:0]    row_lo_q, row_hi_q;

	logic [AW-1:0] sweep_addr_q;
	logic          fill_q;

	logic [7:0]    mem [STORE_BYTES];
	logic [7:0]    rdata_q;
	logic          rd_in_range_q;
	logic          out_valid_q;
	logic [7:0]    out_data_q;

	logic [AW-1:0] draw_addr, read_addr, wr_addr, rd_addr;
	logic [7:0]    wr_data, mask;
	logic [2:0]    row_lo, row_hi;
	logic          wr_en, rd_en, read_in_range;

	always_ff @(posedge clk) begin
		if (cmd.load_cmd) begin
			cmd_q <= in_data;
		end
	end

	// Raw inclusive box per operation, endpoints ordered.
	always_comb begin
		logic signed [17:0] xa, xb, ya, yb, w, h;
		xa = 18'(cmd_q.x_first);
		xb = 18'(cmd_q.x_second);
		ya = 18'(cmd_q.y_first);
		yb = 18'(cmd_q.y_second);
		w  = signed'({2'b00, cmd_q.rect_width});
		h  = signed'({2'b00, cmd_q.rect_height});
		bx0_d = xa;
		bx1_d = xa;
		by0_d = ya;
		by1_d = ya;
		unique case (opcode_t'(cmd_q.operation))
			OP_HLINE: begin
				bx0_d = (xa > xb) ? xb : xa;
				bx1_d = (xa > xb) ? xa : xb;
			end
			OP_VLINE: begin
				by0_d = (ya > yb) ? yb : ya;
				by1_d = (ya > yb) ? ya : yb;
			end
			OP_RECT: begin
				// zero width or height makes the far edge one less than the near one, so the box is empty
				bx1_d = xa + w - 18'sd1;
				by1_d = ya + h - 18'sd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_box) begin
			bx0_q <= bx0_d;
			bx1_q <= bx1_d;
			by0_q <= by0_d;
			by1_q <= by1_d;
		end
	end

	assign cx0 = (bx0_q < 18'sd0) ? 18'sd0 : bx0_q;
	assign cy0 = (by0_q < 18'sd0) ? 18'sd0 : by0_q;
	assign cx1 = (bx1_q > X_MAX) ? X_MAX : bx1_q;
	assign cy1 = (by1_q > Y_MAX) ? Y_MAX : by1_q;

	assign status.box_empty = (cx0 > cx1) || (cy0 > cy1)
		|| (color_t'(cmd_q.color) == INK_KEEP);

	always_ff @(posedge clk) begin
		if (cmd.load_clip) begin
			col_lo_q  <= cx0[CW-1:0];
			col_hi_q  <= cx1[CW-1:0];
			page_lo_q <= cy0[PW+2:3];
			page_hi_q <= cy1[PW+2:3];
			row_lo_q  <= cy0[2:0];
			row_hi_q  <= cy1[2:0];
		end
	end

	// Walk columns inside each page, pages top to bottom.
	always_ff @(posedge clk) begin
		if (cmd.load_clip) begin
			col_q  <= cx0[CW-1:0];
			page_q <= cy0[PW+2:3];
		end else if (cmd.mem_wr) begin
			if (col_q == col_hi_q) begin
				col_q  <= col_lo_q;
				page_q <= page_q + PW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	assign row_lo    = (page_q == page_lo_q) ? row_lo_q : 3'd0;
	assign row_hi    = (page_q == page_hi_q) ? row_hi_q : 3'd7;
	assign mask      = (8'hFF << row_lo) & (8'hFF >> (3'd7 - row_hi));
	assign draw_addr = AW'(AW'(page_q) * AW'(SCREEN_WIDTH) + AW'(col_q));

	assign status.last_byte = (col_q == col_hi_q) && (page_q == page_hi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_addr_q <= '0;
			fill_q       <= 1'b0;
		end else begin
			if (cmd.sweep_start) begin
				fill_q <= cmd.sweep_white;
			end
			if (cmd.sweep_wr) begin
				sweep_addr_q <= status.sweep_last ? '0 : sweep_addr_q + AW'(1);
			end
		end
	end

	assign status.sweep_last = (sweep_addr_q == AW'(STORE_BYTES - 1));

	assign read_in_range = (int'(cmd_q.read_page) < PAGE_COUNT)
		&& (int'(cmd_q.read_column) < SCREEN_WIDTH);
	assign read_addr = AW'(AW'(cmd_q.read_page) * AW'(SCREEN_WIDTH) + AW'(cmd_q.read_column));

	assign wr_en   = cmd.mem_wr || cmd.sweep_wr;
	assign wr_addr = cmd.sweep_wr ? sweep_addr_q : draw_addr;
	assign wr_data = cmd.sweep_wr ? {8{fill_q}} : apply_color(rdata_q, mask, cmd_q.color);
	assign rd_en   = cmd.mem_rd || (cmd.rd_issue && read_in_range);
	assign rd_addr = cmd.rd_issue ? read_addr : draw_addr;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rd_in_range_q <= read_in_range;
		end
		if (cmd.rd_done) begin
			out_data_q <= rd_in_range_q ? rdata_q : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.rd_done) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_data        = out_data_q;
	assign status.out_busy = out_valid_q && !out_ready;
	assign status.op       = opcode_t'(cmd_q.operation);

`ifndef ASSERT_OFF
	a_draw_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_wr |-> (int'(draw_addr) < STORE_BYTES))
		else $error("draw write outside frame store");

	a_col_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_rd |-> (col_q >= col_lo_q) && (col_q <= col_hi_q) && (page_q <= page_hi_q))
		else $error("draw walk left its clipped span");

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_done |-> !out_valid_q)
		else $error("read result overwrote a pending result");

	a_sweep_idle_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_start |-> (sweep_addr_q == '0))
		else $error("sweep started away from the first byte");
`endif

endmodule

[sv/page_framebuffer_draw_engine.sv]
// Top level of the page-organized monochrome framebuffer draw engine.
// The frame store holds SCREEN_WIDTH columns by SCREEN_HEIGHT rows, one byte per
// column per 8-row page (byte = page*SCREEN_WIDTH + column, bit = y mod 8). Each cmd
// transaction carries one command; only a read-byte command produces a rsp transaction,
// with the byte (zero for a page or column off screen). Pixels, lines and rectangles are
// clipped to the screen; color 3 changes none of them and operation 7 changes nothing.
// cmd.ready is high only while the engine is idle. A draw command loads the command,
// its raw box and its clipped box, then reads and writes back each byte it touches,
// i.e. columns times pages of the clipped box. Clear and fill white sweep every byte
// of the store, one store byte per cycle. A read is held while a previous result
// still sits unclaimed on rsp; other commands proceed while that result waits there.
// The frame store memory has a single write port and a single read port.
// After arst_n releases, a clearing pass zeroes the store, one byte per cycle, before
// cmd.ready rises.
module page_framebuffer_draw_engine
	import fbde_pkg::*;
#(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fbde_chan_if.sink   cmd,
	fbde_chan_if.source rsp
);

	// Command and status bundles between the sequencer and the datapath.
	ctrl_cmd_t  ctrl;
	dp_status_t status;
	logic       in_ready;

	// Sequence setup, read-modify-write walks, store sweeps and reads.
	fbde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (ctrl)
	);

	// Hold the command, clip it, and own the frame store and the result register.
	fbde_dp #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctrl),
		.status    (status),
		.in_data   (cmd.data),
		.out_valid (rsp.valid),
		.out_data  (rsp.data),
		.out_ready (rsp.ready)
	);

	assign cmd.ready = in_ready;

endmodule

[tb/page_framebuffer_draw_engine_tb.sv]
// Testbench for the page framebuffer draw engine: random commands against a store predictor.
`timescale 1ns / 1ps

module page_framebuffer_draw_engine_tb;
	import fbde_pkg::*;

	localparam int SCREEN_W     = SCREEN_WIDTH_DEF;
	localparam int SCREEN_H     = SCREEN_HEIGHT_DEF;
	localparam int PAGE_COUNT   = (SCREEN_H + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
	localparam int STORE_BYTES  = SCREEN_W * PAGE_COUNT;
	localparam int RANDOM_ITEMS = 650;
	localparam int MAX_GAP      = 17;
	// Slowest single transaction is a full-screen rectangle, which reads and writes back every store byte.
	localparam int TAIL_CYCLES  = 2 * STORE_BYTES + 64;
	localparam int QUIET_LIMIT  = 5 * TAIL_CYCLES;

	// Mirror of the frame store plus the queue of read bytes still owed by the engine.
	class frame_scoreboard;
		logic [7:0] store_bytes [STORE_BYTES];
		logic [7:0] owed_reads [$];
		int         fail_count;
		int         reads_checked;
		int         op_count [8];

		function new();
			foreach (store_bytes[i]) store_bytes[i] = 8'h00;
			foreach (op_count[i]) op_count[i] = 0;
			fail_count    = 0;
			reads_checked = 0;
		endfunction

		// Clip the inclusive box to the screen, then recolor every pixel in it.
		function void paint_box(int x0, int x1, int y0, int y1, color_t color);
			int         x;
			int         y;
			int         idx;
			logic [7:0] mask;
			if (x0 < 0) x0 = 0;
			if (y0 < 0) y0 = 0;
			if (x1 > SCREEN_W - 1) x1 = SCREEN_W - 1;
			if (y1 > SCREEN_H - 1) y1 = SCREEN_H - 1;
			for (x = x0; x <= x1; x++) begin
				for (y = y0; y <= y1; y++) begin
					idx  = (y / ROWS_PER_PAGE) * SCREEN_W + x;
					mask = 8'h01 << (y % ROWS_PER_PAGE);
					case (color)
						INK_SET:   store_bytes[idx] = store_bytes[idx] | mask;
						INK_CLEAR: store_bytes[idx] = store_bytes[idx] & ~mask;
						INK_FLIP:  store_bytes[idx] = store_bytes[idx] ^ mask;
						default:   ;
					endcase
				end
			end
		endfunction

		function void note_command(cmd_t c);
			int     xa;
			int     xb;
			int     ya;
			int     yb;
			int     w;
			int     h;
			int     t;
			color_t color;
			xa    = int'(c.x_first);
			xb    = int'(c.x_second);
			ya    = int'(c.y_first);
			yb    = int'(c.y_second);
			w     = int'(c.rect_width);
			h     = int'(c.rect_height);
			color = color_t'(c.color);
			op_count[c.operation]++;
			case (opcode_t'(c.operation))
				OP_PIXEL: paint_box(xa, xa, ya, ya, color);
				OP_HLINE: begin
					if (xa > xb) begin
						t  = xa;
						xa = xb;
						xb = t;
					end
					paint_box(xa, xb, ya, ya, color);
				end
				OP_VLINE: begin
					if (ya > yb) begin
						t  = ya;
						ya = yb;
						yb = t;
					end
					paint_box(xa, xa, ya, yb, color);
				end
				OP_RECT: begin
					if (w != 0 && h != 0)
						paint_box(xa, xa + w - 1, ya, ya + h - 1, color);
				end
				OP_CLEAR: foreach (store_bytes[i]) store_bytes[i] = 8'h00;
				OP_FILL:  foreach (store_bytes[i]) store_bytes[i] = 8'hFF;
				OP_READ: begin
					if (c.read_page < PAGE_COUNT && c.read_column < SCREEN_W)
						owed_reads.push_back(store_bytes[c.read_page * SCREEN_W + c.read_column]);
					else
						owed_reads.push_back(8'h00);
				end
				default: ;
			endcase
		endfunction

		function void check_read(logic [7:0] got);
			logic [7:0] want;
			if (owed_reads.size() == 0) begin
				$display("%0t: read_data expected none, actual %02h", $time, got);
				fail_count++;
				return;
			end
			want = owed_reads.pop_front();
			reads_checked++;
			if (got !== want) begin
				$display("%0t: read_data expected %02h, actual %02h", $time, want, got);
				fail_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fbde_chan_if #(.payload_t(cmd_t))       cmd_ch ();
	fbde_chan_if #(.payload_t(logic [7:0])) rsp_ch ();

	page_framebuffer_draw_engine uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	frame_scoreboard board = new();

	// Burst modes: when set, that side stops idling for a stretch of transactions.
	bit sender_eager;
	bit receiver_eager;
	// Last on-screen x_first column and y_first page of a draw; reads lean toward them.
	int focus_col;
	int focus_page;
	int quiet_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Monitor: record accepted commands first, then compare any result byte, at every edge.
	// Values driven by nonblocking assignment at this edge are not visible yet, so both
	// channels are seen as they stood when the edge arrived.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready)
				board.note_command(cmd_ch.data);
			if (rsp_ch.valid && rsp_ch.ready)
				board.check_read(rsp_ch.data);
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			// Drop out if the engine stalls far past its slowest legal transaction.
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: watchdog expired after %0d idle cycles", $time, quiet_cycles);
				$display("page_framebuffer_draw_engine: mismatch");
				$finish;
			end
		end
	end

	// Result side: hold ready low for a random stall before each transaction, or not at all
	// while in a burst stretch.
	initial begin
		int stall;
		forever begin
			stall = receiver_eager ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// Present one command after a random gap and hold it until the engine takes it.
	// Valid is only lowered when a gap follows, so back-to-back transactions keep it high.
	task automatic send_command(cmd_t c);
		int gap;
		gap = sender_eager ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	// Hold off the sender until every owed read byte has come back.
	task automatic drain_reads();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (board.owed_reads.size() != 0);
	endtask

	function automatic cmd_t make_cmd(opcode_t op, int xa, int xb, int ya, int yb, int w, int h,
			color_t color, int page, int column);
		cmd_t c;
		c.operation   = op;
		c.x_first     = xa[15:0];
		c.x_second    = xb[15:0];
		c.y_first     = ya[15:0];
		c.y_second    = yb[15:0];
		c.rect_width  = w[15:0];
		c.rect_height = h[15:0];
		c.color       = color;
		c.read_page   = page[2:0];
		c.read_column = column[6:0];
		return c;
	endfunction

	// Coordinates cluster around the screen, with a share of extremes and raw 16-bit values.
	function automatic int pick_coord(int span);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return int'($signed(16'($urandom)));
		if (r == 1)
			return $urandom_range(0, 1) ? 32767 : -32768;
		return int'($urandom_range(0, span + 15)) - 8;
	endfunction

	// Keep most extents small so rectangles stay cheap; a few are zero, huge or raw.
	function automatic int pick_extent();
		int r;
		r = $urandom_range(0, 19);
		case (r)
			0:       return 0;
			1:       return 65535;
			2:       return int'(16'($urandom));
			3:       return $urandom_range(25, 140);
			default: return $urandom_range(1, 24);
		endcase
	endfunction

	function automatic color_t pick_color();
		return ($urandom_range(0, 11) == 0) ? INK_KEEP : color_t'($urandom_range(0, 2));
	endfunction

	function automatic cmd_t random_command();
		cmd_t c;
		int   r;
		int   xa;
		int   ya;
		// Start from raw values in every field so each bit sees both levels.
		c.x_first     = 16'($urandom);
		c.x_second    = 16'($urandom);
		c.y_first     = 16'($urandom);
		c.y_second    = 16'($urandom);
		c.rect_width  = 16'($urandom);
		c.rect_height = 16'($urandom);
		c.color       = 2'($urandom);
		c.read_page   = 3'($urandom);
		c.read_column = 7'($urandom);
		r = $urandom_range(0, 99);
		if (r < 18)      c.operation = OP_PIXEL;
		else if (r < 32) c.operation = OP_HLINE;
		else if (r < 46) c.operation = OP_VLINE;
		else if (r < 60) c.operation = OP_RECT;
		else if (r < 63) c.operation = OP_CLEAR;
		else if (r < 66) c.operation = OP_FILL;
		else if (r < 69) c.operation = OP_NOP;
		else             c.operation = OP_READ;
		// Shape most commands so they land on the screen and do real work.
		if ($urandom_range(0, 4) != 0) begin
			c.x_first     = 16'(pick_coord(SCREEN_W));
			c.x_second    = 16'(pick_coord(SCREEN_W));
			c.y_first     = 16'(pick_coord(SCREEN_H));
			c.y_second    = 16'(pick_coord(SCREEN_H));
			c.rect_width  = 16'(pick_extent());
			c.rect_height = 16'(pick_extent());
			c.color       = pick_color();
			if (c.operation == OP_READ && $urandom_range(0, 1) == 0) begin
				c.read_page   = 3'(focus_page);
				c.read_column = 7'(focus_col);
			end
		end
		xa = int'(c.x_first);
		ya = int'(c.y_first);
		if (c.operation inside {OP_PIXEL, OP_HLINE, OP_VLINE, OP_RECT}) begin
			if (xa >= 0 && xa < SCREEN_W) focus_col = xa;
			if (ya >= 0 && ya < SCREEN_H) focus_page = ya / ROWS_PER_PAGE;
		end
		return c;
	endfunction

	initial begin
		int n;
		arst_n         <= 1'b0;
		cmd_ch.valid   <= 1'b0;
		cmd_ch.data    <= '0;
		sender_eager   = 1'b0;
		receiver_eager = 1'b0;
		focus_col      = 0;
		focus_page     = 0;
		quiet_cycles   = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: store after reset, fill and clear, off-screen pixels, reversed and
		// off-screen lines, a rectangle whose far edge must not wrap, empty rectangles,
		// the unused color and the unused operation, reads at the store corners.
		send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, INK_SET, 0, 0));
		send_command(make_cmd(OP_FILL, 0, 0, 0, 0, 0, 0, INK_SET, 0, 0));
		send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, INK_SET, 7, 127));
		send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, INK_SET, 3, 64));
		send_command(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, INK_SET, 0, 0));
		send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, INK_SET, 7, 127));
		send_command(make_cmd(OP_PIXEL, 0, 0, 0, 0, 0, 0, INK_SET, 0, 0));
		send_command(make_cmd(OP_PIXEL, 127, 0, 63, 0, 0, 0, INK_SET, 0, 0));
		send_command(make_cmd(OP_PIXEL, -1, 0, 0, 0, 0, 0, INK_SET, 0, 0));
		send_command(make_cmd(OP_PIXEL, 128, 0, 5, 0, 0, 0, INK_SET, 0, 0));
		send_command(make_cmd(OP_PIXEL, 5, 0, 64, 0, 0, 0, INK_SET, 0, 0));
		send_command(make_cmd(OP_PIXEL, -32768, 32767, 32767, -32768, 65535, 65535,
				INK_SET, 7, 127));
		send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, INK_SET, 0, 0));
		send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, INK_SET, 7, 127));
		send_command(make_cmd(OP_HLINE, 32767, -32768, 9, 0, 0, 0, INK_FLIP, 0, 0));
		send_command(make_cmd(OP_HLINE, 0, 127, -1, 0, 0, 0, INK_SET, 0, 0));
		send_command(make_cmd(OP_VLINE, 3, 0, 70, -5, 0, 0, INK_SET, 0, 0));
		send_command(make_cmd(OP_VLINE, 128, 0, 0, 63, 0, 0, INK_SET, 0, 0));
		send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, INK_SET, 1, 50));
		send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, INK_SET, 4, 3));
		send_command(make_cmd(OP_RECT, -32768, 0, -32768, 0, 65535, 65535, INK_FLIP, 0, 0));
		send_command(make_cmd(OP_RECT, 10, 0, 10, 0, 0, 10, INK_CLEAR, 0, 0));
		send_command(make_cmd(OP_RECT, 10, 0, 10, 0, 10, 0, INK_CLEAR, 0, 0));
		send_command(make_cmd(OP_RECT, 0, 0, 0, 0, 20, 20, INK_KEEP, 0, 0));
		send_command(make_cmd(OP_NOP, 0, 0, 0, 0, 0, 0, INK_SET, 0, 0));
		send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, INK_SET, 1, 50));
		send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, INK_SET, 0, 3));
		drain_reads();

		// Random part: pick burst modes anew every fifty transactions and now and then drain
		// the outstanding reads before going on.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0) begin
				sender_eager   = ($urandom_range(0, 3) == 0);
				receiver_eager = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 59) == 0)
				drain_reads();
			send_command(random_command());
		end

		// Wait out owed reads, then give the last draw time to finish.
		drain_reads();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display(
			"Sent %0d pixel, %0d hline, %0d vline, %0d rect, %0d clear, %0d fill, %0d nop",
			board.op_count[OP_PIXEL], board.op_count[OP_HLINE], board.op_count[OP_VLINE],
			board.op_count[OP_RECT], board.op_count[OP_CLEAR], board.op_count[OP_FILL],
			board.op_count[OP_NOP]);
		$display("Byte reads compared with the predicted store: %0d, failures: %0d",
				board.reads_checked, board.fail_count);
		if (board.fail_count == 0)
			$display("page_framebuffer_draw_engine: match");
		else
			$display("page_framebuffer_draw_engine: mismatch");
		$finish;
	end

endmodule
